>>> rtl/tpc_pkg.sv
// Shared types and constants for the touch three point calibration unit.
// No dependencies.
`default_nettype none

package tpc_pkg;

    localparam int COORD_W = 12;                  // raw reading and pixel width
    localparam int QUOT_W  = 11;                  // half of a 12-bit screen size
    localparam int NUM_W   = COORD_W + QUOT_W;    // scaled numerator
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_ORIGIN   = 3'd0,
        CFG_Y_ORIGIN   = 3'd1,
        CFG_X_MIDDLE   = 3'd2,
        CFG_Y_MIDDLE   = 3'd3,
        CFG_X_FAR      = 3'd4,
        CFG_Y_FAR      = 3'd5,
        CFG_RAW_BYPASS = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [COORD_W-1:0] raw_x;
        logic [COORD_W-1:0] raw_y;
        logic               touch_valid;
    } sample_t;

    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
    } pos_t;

    // Per-axis side info that travels alongside the divider.
    typedef struct packed {
        logic [COORD_W-1:0] raw;
        logic               hi;     // reading above middle point
        logic               sat;    // clamps to 0 (low) or full size (high)
        logic               zero;   // empty lower segment
        logic [COORD_W-1:0] den;
    } axis_ctl_t;

endpackage

`default_nettype wire

>>> rtl/touch_three_point_calibration_unit.sv
// Touch calibration top level: maps raw converter pairs to screen pixels.
// Depends on tpc_pkg.
//
//   port group          dir  protocol
//   start/busy/sample   in   transaction taken when start && !busy
//   done/pos            out  one-cycle strobe, no back pressure
//   cfg_we/idx/data     in   register write on any edge with cfg_we
//
// One transaction per clock. From accept to done each transaction passes a
// compare/select stage, a constant-multiply stage, one restoring divide
// stage per quotient bit, and the output register. busy is never raised.
// Reset clears the valid bits and loads the default calibration points.
`default_nettype none

module touch_three_point_calibration_unit #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire tpc_pkg::sample_t             sample,
    output logic                              done,
    output tpc_pkg::pos_t                     pos,
    input  wire logic                         cfg_we,
    input  wire logic [tpc_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [tpc_pkg::COORD_W-1:0]  cfg_data
);
    import tpc_pkg::*;

    localparam int LATENCY = QUOT_W + 3;
    localparam logic [QUOT_W-1:0] HALF_X = QUOT_W'(SCREEN_WIDTH / 2);
    localparam logic [QUOT_W-1:0] HALF_Y = QUOT_W'(SCREEN_HEIGHT / 2);

    // calibration registers, index 0 = X, 1 = Y
    logic [COORD_W-1:0] origin_reg [2];
    logic [COORD_W-1:0] middle_reg [2];
    logic [COORD_W-1:0] far_reg    [2];
    logic               bypass_reg;

    // shared control pipeline
    logic a_valid_reg, a_tv_reg, a_byp_reg;
    logic v_reg   [QUOT_W+1];
    logic tv_reg  [QUOT_W+1];
    logic byp_reg [QUOT_W+1];
    logic done_reg;

    logic [COORD_W-1:0] pos_reg    [2];
    logic [QUOT_W-1:0]  last_quot  [2];
    logic               last_plain [2];
    logic               accept;

    assign accept = start && !busy;
    assign busy   = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            middle_reg[0] <= COORD_W'(2048);
            middle_reg[1] <= COORD_W'(2048);
            far_reg[0]    <= '1;
            far_reg[1]    <= '1;
            bypass_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_X_ORIGIN:   origin_reg[0] <= cfg_data;
                CFG_Y_ORIGIN:   origin_reg[1] <= cfg_data;
                CFG_X_MIDDLE:   middle_reg[0] <= cfg_data;
                CFG_Y_MIDDLE:   middle_reg[1] <= cfg_data;
                CFG_X_FAR:      far_reg[0]    <= cfg_data;
                CFG_Y_FAR:      far_reg[1]    <= cfg_data;
                CFG_RAW_BYPASS: bypass_reg    <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            for (int s = 0; s <= QUOT_W; s++)
            begin
                v_reg[s] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            v_reg[0]    <= a_valid_reg;
            for (int s = 0; s < QUOT_W; s++)
            begin
                v_reg[s+1] <= v_reg[s];
            end
            done_reg <= v_reg[QUOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        a_tv_reg   <= sample.touch_valid;
        a_byp_reg  <= bypass_reg;
        tv_reg[0]  <= a_tv_reg;
        byp_reg[0] <= a_byp_reg;
        for (int s = 0; s < QUOT_W; s++)
        begin
            tv_reg[s+1]  <= tv_reg[s];
            byp_reg[s+1] <= byp_reg[s];
        end
    end

    for (genvar a = 0; a < 2; a++)
    begin : g_axis
        localparam int SIZE = (a == 0) ? SCREEN_WIDTH : SCREEN_HEIGHT;
        localparam logic [COORD_W-1:0] SIZE_C = COORD_W'(SIZE);
        localparam logic [QUOT_W-1:0]  HALF_C = QUOT_W'(SIZE / 2);

        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] diff_next;
        axis_ctl_t          ctl_next;
        axis_ctl_t          ctl_a_reg;
        logic [COORD_W-1:0] diff_a_reg;

        axis_ctl_t          ctl_reg  [QUOT_W+1];
        logic [NUM_W-1:0]   rem_reg  [QUOT_W];
        logic [QUOT_W-1:0]  quot_reg [QUOT_W+1];
        logic [NUM_W-1:0]   trial    [QUOT_W];
        logic               ge       [QUOT_W];
        logic [NUM_W-1:0]   rem_next [QUOT_W-1];
        logic [QUOT_W-1:0]  quot_next [QUOT_W];
        logic [COORD_W-1:0] res_next;

        if (a == 0)
        begin : g_rx
            assign r = sample.raw_x;
        end
        else
        begin : g_ry
            assign r = sample.raw_y;
        end

        // segment select on entry
        always_comb
        begin
            ctl_next.raw = r;
            ctl_next.hi  = r > middle_reg[a];
            if (ctl_next.hi)
            begin
                ctl_next.sat = r > far_reg[a];
                ctl_next.den = far_reg[a] - middle_reg[a];
                diff_next    = r - middle_reg[a];
            end
            else
            begin
                ctl_next.sat = r < origin_reg[a];
                ctl_next.den = middle_reg[a] - origin_reg[a];
                diff_next    = r - origin_reg[a];
            end
            ctl_next.zero = !ctl_next.hi && (ctl_next.den == '0);
        end

        // restoring divide, one quotient bit per stage
        always_comb
        begin
            for (int s = 0; s < QUOT_W; s++)
            begin
                trial[s] = NUM_W'(ctl_reg[s].den) << (QUOT_W - 1 - s);
                ge[s]    = rem_reg[s] >= trial[s];
                quot_next[s] = quot_reg[s]
                             | (ge[s] ? (QUOT_W'(1) << (QUOT_W - 1 - s)) : '0);
            end
            for (int s = 0; s < QUOT_W - 1; s++)
            begin
                rem_next[s] = ge[s] ? rem_reg[s] - trial[s] : rem_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            ctl_a_reg   <= ctl_next;
            diff_a_reg  <= diff_next;
            ctl_reg[0]  <= ctl_a_reg;
            rem_reg[0]  <= NUM_W'(diff_a_reg) * NUM_W'(HALF_C);
            quot_reg[0] <= '0;
            for (int s = 0; s < QUOT_W; s++)
            begin
                ctl_reg[s+1]  <= ctl_reg[s];
                quot_reg[s+1] <= quot_next[s];
            end
            for (int s = 0; s < QUOT_W - 1; s++)
            begin
                rem_reg[s+1] <= rem_next[s];
            end
        end

        always_comb
        begin
            if (!tv_reg[QUOT_W])
                res_next = '0;
            else if (byp_reg[QUOT_W])
                res_next = ctl_reg[QUOT_W].raw;
            else if (ctl_reg[QUOT_W].sat)
                res_next = ctl_reg[QUOT_W].hi ? SIZE_C : '0;
            else if (ctl_reg[QUOT_W].zero)
                res_next = '0;
            else
                res_next = (ctl_reg[QUOT_W].hi ? COORD_W'(HALF_C) : '0)
                         + COORD_W'(quot_reg[QUOT_W]);
        end

        always_ff @(posedge clk)
        begin
            pos_reg[a] <= res_next;
        end

        assign last_quot[a]  = quot_reg[QUOT_W];
        assign last_plain[a] = !ctl_reg[QUOT_W].sat && !ctl_reg[QUOT_W].zero;
    end

    assign done      = done_reg;
    assign pos.pos_x = pos_reg[0];
    assign pos.pos_y = pos_reg[1];

    // every accepted transaction comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("transaction did not complete at fixed latency");

    // scaled segment offset never exceeds half the screen
    a_quot_x: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[QUOT_W] && last_plain[0] |-> last_quot[0] <= HALF_X)
        else $error("X quotient out of range");

    a_quot_y: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[QUOT_W] && last_plain[1] |-> last_quot[1] <= HALF_Y)
        else $error("Y quotient out of range");

    // an invalid sample yields zero on both axes
    a_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[QUOT_W] && !tv_reg[QUOT_W] |=> done && pos == '0)
        else $error("invalid sample gave nonzero position");

endmodule

`default_nettype wire
